// ===== rtl/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// pal_pkg: shared definitions for the positional array list
// Field widths, request and status codes, and the packing of the stream
// words used by the list block and its entry store.
// ----------------------------------------------------------------------------
package pal_pkg;

   localparam int PAL_DEPTH = 64;

   localparam int MODE_W   = 4;
   localparam int POS_W    = 7;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   localparam int REQ_FIELDS_W = MODE_W + POS_W + DATA_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = STATUS_W + DATA_W + 1 + COUNT_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_TDATA_W - RSP_FIELDS_W;

   localparam logic [MODE_W-1:0] MODE_INS_FRONT = 4'd0;
   localparam logic [MODE_W-1:0] MODE_APPEND    = 4'd1;
   localparam logic [MODE_W-1:0] MODE_INS_AT    = 4'd2;
   localparam logic [MODE_W-1:0] MODE_DEL_FIRST = 4'd3;
   localparam logic [MODE_W-1:0] MODE_DEL_LAST  = 4'd4;
   localparam logic [MODE_W-1:0] MODE_DEL_AT    = 4'd5;
   localparam logic [MODE_W-1:0] MODE_READ      = 4'd6;
   localparam logic [MODE_W-1:0] MODE_WRITE     = 4'd7;
   localparam logic [MODE_W-1:0] MODE_SEARCH    = 4'd8;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_POS   = 2'd3;

endpackage

// ===== rtl/pal_mem.sv =====
// ----------------------------------------------------------------------------
// pal_mem: entry store of the positional array list
// Single write port and single read port; the read data is registered, so it
// appears in the cycle after the address.
// ----------------------------------------------------------------------------
module pal_mem
   import pal_pkg::*;
#(
   parameter int DEPTH = PAL_DEPTH
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [DATA_W-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [DATA_W-1:0]                       rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read every cycle; the sequencer only looks at the data it asked for.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/positional_array_list.sv =====
// ----------------------------------------------------------------------------
// positional_array_list: bounded ordered list of signed 32-bit values
// Request sequencer, entry count and response register around one entry store.
// ----------------------------------------------------------------------------
// The block keeps an ordered list of up to DEPTH signed 32-bit values and
// answers one request word with one response word. Requests insert at the
// front, append, insert at a position, delete the first, last or a given
// entry, read, write or search; the response gives a status (ok, full, empty,
// position out of range), the value read, a found flag and the new count.
// All entries live in one memory with a single read port and a single write
// port, and every move of an entry passes through that read port, one entry
// per cycle. An insert or delete takes longer the more entries it moves, and
// a search the more entries the list holds; a write, a delete of the last
// entry and a rejected request go straight to the response register. The
// worst case is a search of a full list.
// A new request word is taken only while the sequencer is idle, but it may be
// taken while the previous response word still waits on the output. The list
// starts empty after reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module positional_array_list
   import pal_pkg::*;
#(
   parameter int DEPTH = PAL_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata, from bit 0 up: mode[3:0], position[10:4], value[42:11], zero pad
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // rsp_tdata, from bit 0 up: status[1:0], read_value[33:2], found[34],
   // count[41:35], zero pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Sequencer states: idle, shift up for an insert, shift down for a
   // delete, single read, search scan, and hand-over to the response register.
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_UP   = 6'b000010,
      ST_DOWN = 6'b000100,
      ST_READ = 6'b001000,
      ST_SCAN = 6'b010000,
      ST_RESP = 6'b100000
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic [ADDR_W-1:0]        lim_ff, lim_in;
   logic [DATA_W-1:0]        val_ff, val_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic [DATA_W-1:0]        rd_ff, rd_in;
   logic                     found_ff, found_in;
   logic                     prim_ff, prim_in;
   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0]   rsp_tdata_ff, rsp_tdata_in;

   logic [MODE_W-1:0]        req_mode;
   logic [POS_W-1:0]         req_pos;
   logic [DATA_W-1:0]        req_value;
   logic [CMP_W-1:0]         pos_ext;
   logic [CMP_W-1:0]         cnt_ext;
   logic                     full;
   logic                     empty;
   logic [ADDR_W-1:0]        addr;

   logic                     mem_wr_en;
   logic [ADDR_W-1:0]        mem_wr_addr;
   logic [DATA_W-1:0]        mem_wr_data;
   logic [ADDR_W-1:0]        mem_rd_addr;
   logic [DATA_W-1:0]        mem_rd_data;

   pal_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign req_mode  = req_tdata[MODE_W-1:0];
   assign req_pos   = req_tdata[MODE_W +: POS_W];
   assign req_value = req_tdata[MODE_W + POS_W +: DATA_W];

   assign pos_ext = CMP_W'(req_pos);
   assign cnt_ext = CMP_W'(count_ff);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign addr    = idx_ff[ADDR_W-1:0];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      lim_in        = lim_ff;
      val_in        = val_ff;
      status_in     = status_ff;
      rd_in         = rd_ff;
      found_in      = found_ff;
      prim_in       = prim_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = addr;
      mem_wr_data   = val_ff;
      mem_rd_addr   = addr;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               // Decide the status at once; only accepted work goes on.
               val_in    = req_value;
               status_in = STAT_OK;
               rd_in     = '0;
               found_in  = 1'b0;
               prim_in   = 1'b0;
               state_in  = ST_RESP;
               if (req_mode == MODE_INS_FRONT || req_mode == MODE_APPEND) begin
                  if (full) begin
                     status_in = STAT_FULL;
                  end else begin
                     idx_in   = count_ff;
                     lim_in   = (req_mode == MODE_APPEND) ? count_ff[ADDR_W-1:0] : '0;
                     state_in = ST_UP;
                  end
               end else if (req_mode == MODE_INS_AT) begin
                  if (pos_ext > cnt_ext) begin
                     status_in = STAT_POS;
                  end else if (full) begin
                     status_in = STAT_FULL;
                  end else begin
                     idx_in   = count_ff;
                     lim_in   = pos_ext[ADDR_W-1:0];
                     state_in = ST_UP;
                  end
               end else if (req_mode == MODE_DEL_FIRST) begin
                  if (empty) begin
                     status_in = STAT_EMPTY;
                  end else begin
                     idx_in   = '0;
                     state_in = ST_DOWN;
                  end
               end else if (req_mode == MODE_DEL_LAST) begin
                  if (empty) begin
                     status_in = STAT_EMPTY;
                  end else begin
                     count_in = count_ff - 1'b1;
                  end
               end else if (req_mode == MODE_DEL_AT || req_mode == MODE_READ ||
                            req_mode == MODE_WRITE) begin
                  if (empty) begin
                     status_in = STAT_EMPTY;
                  end else if (pos_ext >= cnt_ext) begin
                     status_in = STAT_POS;
                  end else if (req_mode == MODE_DEL_AT) begin
                     idx_in   = pos_ext[CNT_W-1:0];
                     state_in = ST_DOWN;
                  end else if (req_mode == MODE_READ) begin
                     idx_in   = pos_ext[CNT_W-1:0];
                     state_in = ST_READ;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = pos_ext[ADDR_W-1:0];
                     mem_wr_data = req_value;
                  end
               end else if (req_mode == MODE_SEARCH) begin
                  idx_in = '0;
                  if (!empty) begin
                     state_in = ST_SCAN;
                  end
               end
            end
         end

         ST_UP: begin
            // Walk down from the tail, copying each entry one place up,
            // then drop the new value into the gap.
            if (addr == lim_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = lim_ff;
               mem_wr_data = val_ff;
               count_in    = count_ff + 1'b1;
               state_in    = ST_RESP;
            end else if (!prim_ff) begin
               mem_rd_addr = addr - ADDR_W'(1);
               prim_in     = 1'b1;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = addr;
               mem_wr_data = mem_rd_data;
               mem_rd_addr = addr - ADDR_W'(2);
               idx_in      = idx_ff - 1'b1;
            end
         end

         ST_DOWN: begin
            // Walk up from the removed slot, copying each later entry down.
            if (idx_ff + 1'b1 == count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = ST_RESP;
            end else if (!prim_ff) begin
               mem_rd_addr = addr + ADDR_W'(1);
               prim_in     = 1'b1;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = addr;
               mem_wr_data = mem_rd_data;
               mem_rd_addr = addr + ADDR_W'(2);
               idx_in      = idx_ff + 1'b1;
            end
         end

         ST_READ: begin
            if (!prim_ff) begin
               prim_in = 1'b1;
            end else begin
               rd_in    = mem_rd_data;
               state_in = ST_RESP;
            end
         end

         ST_SCAN: begin
            // One address issued and one compare made in each cycle.
            if (prim_ff && mem_rd_data == val_ff) begin
               found_in = 1'b1;
            end
            if (idx_ff < count_ff) begin
               idx_in  = idx_ff + 1'b1;
               prim_in = 1'b1;
            end else begin
               prim_in = 1'b0;
               if (!prim_ff) begin
                  state_in = ST_RESP;
               end
            end
         end

         ST_RESP: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {{RSP_PAD_W{1'b0}}, COUNT_W'(count_ff), found_ff,
                                rd_ff, status_ff};
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         prim_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         prim_ff       <= prim_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      lim_ff       <= lim_in;
      val_ff       <= val_in;
      status_ff    <= status_in;
      rd_ff        <= rd_in;
      found_ff     <= found_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

endmodule

// ===== tb/pal_list_checker.sv =====
// ----------------------------------------------------------------------------
// pal_list_checker: response checker for the positional array list
// Watches the request and response streams, keeps its own copy of the list,
// works out the response word for every accepted request and compares it,
// field by field, with the oldest response still owed.
// ----------------------------------------------------------------------------
module pal_list_checker
   import pal_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata, from bit 0 up: mode, position, value, zero pad
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // rsp_tdata, from bit 0 up: status, read_value, found, count, zero pad
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   output int                     mismatches,
   output int                     pending,
   output int                     words_checked,
   output int                     full_seen,
   output int                     empty_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRINT_CAP = 40;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] rd;
      logic                     found;
      logic [COUNT_W-1:0]       count;
   } list_reply_type;

   logic signed [DATA_W-1:0] list_mem [PAL_DEPTH];
   logic [COUNT_W-1:0]       list_len;
   list_reply_type           owed_replies [$];

   task automatic report_mismatch(input string what, input logic [63:0] want_v,
                                  input logic [63:0] got_v);
      if (mismatches < PRINT_CAP)
         $display("MISMATCH at %0t: %s expected %0h got %0h", $time, what, want_v, got_v);
      mismatches++;
   endtask

   // Opens a gap at slot p (p <= list_len < depth) and stores v there.
   function automatic void open_slot(input int p, input logic signed [DATA_W-1:0] v);
      int i;
      for (i = int'(list_len); i > p; i--)
         list_mem[i] = list_mem[i-1];
      list_mem[p] = v;
      list_len++;
   endfunction

   // Removes slot p (p < list_len) and closes the gap.
   function automatic void close_slot(input int p);
      int i;
      for (i = p; i + 1 < int'(list_len); i++)
         list_mem[i] = list_mem[i+1];
      list_len--;
   endfunction

   function automatic list_reply_type apply_request(input logic [MODE_W-1:0] mode,
                                                    input logic [POS_W-1:0] pos,
                                                    input logic signed [DATA_W-1:0] val);
      list_reply_type r;
      logic           full;
      logic           empty;
      int             i;
      r     = '0;
      full  = (int'(list_len) >= PAL_DEPTH);
      empty = (list_len == '0);
      case (mode)
         MODE_INS_FRONT: begin
            if (full) r.status = STAT_FULL;
            else open_slot(0, val);
         end
         MODE_APPEND: begin
            if (full) r.status = STAT_FULL;
            else open_slot(int'(list_len), val);
         end
         MODE_INS_AT: begin
            // The position check wins over the full check.
            if (pos > list_len) r.status = STAT_POS;
            else if (full) r.status = STAT_FULL;
            else open_slot(int'(pos), val);
         end
         MODE_DEL_FIRST: begin
            if (empty) r.status = STAT_EMPTY;
            else close_slot(0);
         end
         MODE_DEL_LAST: begin
            if (empty) r.status = STAT_EMPTY;
            else list_len--;
         end
         MODE_DEL_AT, MODE_READ, MODE_WRITE: begin
            if (empty) r.status = STAT_EMPTY;
            else if (pos >= list_len) r.status = STAT_POS;
            else if (mode == MODE_DEL_AT) close_slot(int'(pos));
            else if (mode == MODE_READ) r.rd = list_mem[int'(pos)];
            else list_mem[int'(pos)] = val;
         end
         MODE_SEARCH: begin
            for (i = 0; i < int'(list_len); i++)
               if (list_mem[i] == val) r.found = 1'b1;
         end
         default: ;
      endcase
      r.count = list_len;
      return r;
   endfunction

   always @(posedge clock) begin
      list_reply_type want;
      list_reply_type got;
      if (reset) begin
         owed_replies.delete();
         list_len      = '0;
         pending       = 0;
         mismatches    = 0;
         words_checked = 0;
         full_seen     = 0;
         empty_seen    = 0;
      end else begin
         // Responses are retired before the request of the same edge is
         // predicted, since a response always belongs to an earlier request.
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tdata[0 +: STATUS_W];
            got.rd     = rsp_tdata[STATUS_W +: DATA_W];
            got.found  = rsp_tdata[STATUS_W + DATA_W];
            got.count  = rsp_tdata[STATUS_W + DATA_W + 1 +: COUNT_W];
            words_checked++;
            if (got.status == STAT_FULL) full_seen++;
            if (got.status == STAT_EMPTY) empty_seen++;
            if (owed_replies.size() == 0) begin
               report_mismatch("response word with no request outstanding", '0,
                               64'(rsp_tdata));
            end else begin
               want = owed_replies.pop_front();
               if (got.status != want.status)
                  report_mismatch("status", 64'(want.status), 64'(got.status));
               if (got.rd != want.rd)
                  report_mismatch("read_value", 64'(unsigned'(want.rd)),
                                  64'(unsigned'(got.rd)));
               if (got.found != want.found)
                  report_mismatch("found", 64'(want.found), 64'(got.found));
               if (got.count != want.count)
                  report_mismatch("count", 64'(want.count), 64'(got.count));
               if (rsp_tdata[RSP_TDATA_W-1:RSP_FIELDS_W] != '0)
                  report_mismatch("pad bits", '0,
                                  64'(rsp_tdata[RSP_TDATA_W-1:RSP_FIELDS_W]));
            end
         end
         if (req_tvalid && req_tready)
            owed_replies.push_back(apply_request(req_tdata[0 +: MODE_W],
                                                 req_tdata[MODE_W +: POS_W],
                                                 req_tdata[MODE_W + POS_W +: DATA_W]));
         pending = owed_replies.size();
      end
   end

endmodule

// ===== tb/positional_array_list_test.sv =====
// ----------------------------------------------------------------------------
// positional_array_list_test: stream test of the positional array list
// Drives directed and random request words into the list block under three
// mixes of sender and receiver idling, with one long receiver hold-off, and
// leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module positional_array_list_test
   import pal_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   // Modes above search are unused; the block must answer them and change
   // nothing.
   localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 4'd9;
   localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 4'd15;

   localparam int WORDS_PER_PHASE = 330;
   localparam int HOLD_CYCLES     = 300;
   // Nothing legitimate is silent for this long: the hold-off above plus the
   // longest request, a search of a full list, and the longest random stall.
   localparam int STALL_LIMIT     = 4000;
   localparam int DRAIN_CYCLES    = PAL_DEPTH + 16;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int mismatches;
   int pending;
   int words_checked;
   int full_seen;
   int empty_seen;

   int send_idle;
   int recv_idle;
   int words_sent;
   int hold_asks;
   int hold_seen = 0;
   int hold_left = 0;
   int quiet_cycles;

   logic [MODE_W-1:0] fill_modes  [3] = '{MODE_INS_FRONT, MODE_APPEND, MODE_INS_AT};
   logic [MODE_W-1:0] drain_modes [3] = '{MODE_DEL_FIRST, MODE_DEL_LAST, MODE_DEL_AT};

   positional_array_list #(
      .DEPTH (PAL_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   pal_list_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .mismatches    (mismatches),
      .pending       (pending),
      .words_checked (words_checked),
      .full_seen     (full_seen),
      .empty_seen    (empty_seen)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // The receiver decides its ready at every falling edge. A hold-off asked
   // for by the stimulus process is counted down here, so that the sender
   // keeps offering words while the response side is blocked.
   always @(negedge clock) begin
      if (hold_asks != hold_seen) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // The watchdog counts cycles in which neither stream moves a word.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no word moved for %0d cycles, %0d responses owed",
                  STALL_LIMIT, pending);
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Packs one request word and offers it until the block accepts it. The
   // task is entered at a falling edge and returns at the next falling edge
   // after the word has been taken, so valid is written once per step.
   task automatic offer_request(input logic [MODE_W-1:0] mode,
                                input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] val);
      logic [REQ_TDATA_W-1:0] w;
      w = '0;
      w[0 +: MODE_W]              = mode;
      w[MODE_W +: POS_W]          = pos;
      w[MODE_W + POS_W +: DATA_W] = val;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   // Mostly positions inside the list range, with a few very small ones so
   // that positional work near the front is frequent, and some out beyond
   // any possible count.
   function automatic logic [POS_W-1:0] pick_position();
      int r;
      r = $urandom_range(9);
      if (r == 0) return POS_W'($urandom_range(127));
      if (r <= 3) return POS_W'($urandom_range(3));
      return POS_W'($urandom_range(PAL_DEPTH));
   endfunction

   // Small values repeat often enough for searches to hit; the extremes of
   // the signed range turn up regularly as well.
   function automatic logic [DATA_W-1:0] pick_value();
      int r;
      r = $urandom_range(9);
      if (r == 0) begin
         case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      if (r <= 4) return DATA_W'($urandom_range(15));
      return $urandom;
   endfunction

   task automatic wait_until_answered();
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      int phase;
      int phase_end;
      int kind;
      int n;
      logic [MODE_W-1:0] m;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      send_idle  = 18;
      recv_idle  = 83;
      words_sent = 0;
      hold_asks  = 0;

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. Every removal, access and write on the empty list,
      // then a search of the empty list and an insert past the end.
      offer_request(MODE_READ,      7'd0,   32'h0000_0000);
      offer_request(MODE_DEL_FIRST, 7'd0,   32'h0000_0000);
      offer_request(MODE_DEL_LAST,  7'd0,   32'h0000_0000);
      offer_request(MODE_DEL_AT,    7'd0,   32'h0000_0000);
      offer_request(MODE_WRITE,     7'd0,   32'h1234_5678);
      offer_request(MODE_SEARCH,    7'd0,   32'h0000_0000);
      offer_request(MODE_INS_AT,    7'd1,   32'h0000_0001);
      // Build a short list with the signed extremes, inserting at the front,
      // at the end, at the count and in the middle.
      offer_request(MODE_INS_AT,    7'd0,   32'h8000_0000);
      offer_request(MODE_APPEND,    7'd0,   32'h7FFF_FFFF);
      offer_request(MODE_INS_FRONT, 7'd0,   32'hFFFF_FFFF);
      offer_request(MODE_INS_AT,    7'd3,   32'h0000_0000);
      offer_request(MODE_INS_AT,    7'd1,   32'h0000_0005);
      offer_request(MODE_SEARCH,    7'd127, 32'h7FFF_FFFF);
      offer_request(MODE_SEARCH,    7'd0,   32'h0000_3039);
      // Reads at the last entry, at the count and at the top position.
      offer_request(MODE_READ,      7'd4,   32'h0000_0000);
      offer_request(MODE_READ,      7'd5,   32'h0000_0000);
      offer_request(MODE_READ,      7'd127, 32'hFFFF_FFFF);
      offer_request(MODE_WRITE,     7'd2,   32'hA5A5_A5A5);
      offer_request(MODE_READ,      7'd2,   32'h0000_0000);
      // Deletes in the middle, at the count, at the front and at the end.
      offer_request(MODE_DEL_AT,    7'd1,   32'h0000_0000);
      offer_request(MODE_DEL_AT,    7'd4,   32'h0000_0000);
      offer_request(MODE_DEL_FIRST, 7'd0,   32'h0000_0000);
      offer_request(MODE_DEL_LAST,  7'd0,   32'h0000_0000);
      // The lowest and highest unused modes, the first with every other bit set.
      offer_request(MODE_UNUSED_LO, 7'd127, 32'hFFFF_FFFF);
      offer_request(MODE_UNUSED_HI, 7'd64,  32'h8000_0000);

      // The sender pauses here until every owed response has come back.
      req_tvalid <= 1'b0;
      @(negedge clock);
      wait_until_answered();

      // Random part in three idling mixes. Fill and drain bursts drive the
      // list to full and back to empty; mixed runs stir every request kind,
      // and short noise runs send any bit pattern at all.
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle = 18;
               recv_idle = 83;
            end
            1: begin
               send_idle = 83;
               recv_idle = 18;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
               // A long receiver hold-off while words keep coming, so that
               // the block backs up and stalls its request side.
               hold_asks++;
            end
         endcase
         phase_end = words_sent + WORDS_PER_PHASE;
         while (words_sent < phase_end) begin
            kind = $urandom_range(9);
            case (kind)
               0, 1: begin
                  n = $urandom_range(72, 20);
                  repeat (n)
                     offer_request(fill_modes[$urandom_range(2)], pick_position(),
                                   pick_value());
               end
               2, 3: begin
                  n = $urandom_range(72, 20);
                  repeat (n)
                     offer_request(drain_modes[$urandom_range(2)], pick_position(),
                                   pick_value());
               end
               9: begin
                  n = $urandom_range(10, 3);
                  repeat (n)
                     offer_request(MODE_W'($urandom), POS_W'($urandom), $urandom);
               end
               default: begin
                  n = $urandom_range(30, 5);
                  repeat (n) begin
                     if ($urandom_range(15) == 0)
                        m = MODE_W'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
                     else
                        m = MODE_W'($urandom_range(MODE_SEARCH));
                     offer_request(m, pick_position(), pick_value());
                  end
               end
            endcase
         end
         req_tvalid <= 1'b0;
         @(negedge clock);
         wait_until_answered();
      end

      // Every word has been accepted and answered; let the block settle in
      // case a stray response follows.
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Summary: %0d request words driven, %0d response words checked",
               words_sent, words_checked);
      $display("Summary: %0d full-list and %0d empty-list replies over three idling mixes",
               full_seen, empty_seen);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
